/* design/cigar_query_interval_trim_macros.svh */
// Assertion macros used by the checker.
`ifndef CIGAR_QUERY_INTERVAL_TRIM_MACROS_SVH
`define CIGAR_QUERY_INTERVAL_TRIM_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CQIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CQIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cqit_pkg.sv */
`timescale 1ns / 1ps

package cqit_pkg;

    localparam int CODE_W       = 4;
    localparam int LEN_W        = 28;
    localparam int POS_W        = 31;
    localparam int CUR_W        = 32;
    localparam int ENTRY_W      = LEN_W + CODE_W;
    localparam int MAX_HELD_DEF = 8;

    // M, I, S, =, X consume the query
    localparam logic [15:0] CONSUME_MASK = 16'h0193;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH,
        S_OP,
        S_END
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic emit_held;
        logic emit_op;
        logic emit_end;
    } cmd_t;

    typedef struct packed {
        logic emit_now;
        logic flush_now;
        logic flush_last;
        logic rec_last;
        logic out_free;
    } status_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [CUR_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (|v[CUR_W-1:LEN_W])
        begin
            r = '1;
        end
        else
        begin
            r = v[LEN_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/cqit_datapath.sv */
`timescale 1ns / 1ps

module cqit_datapath #(
    parameter int MAX_HELD = cqit_pkg::MAX_HELD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cqit_pkg::cmd_t                 cmd,
    output cqit_pkg::status_t              status,
    input  logic [cqit_pkg::CODE_W-1:0]    op_code,
    input  logic [cqit_pkg::LEN_W-1:0]     op_length,
    input  logic [cqit_pkg::POS_W-1:0]     trim_start,
    input  logic [cqit_pkg::POS_W-1:0]     trim_end,
    input  logic                           last_op,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cqit_pkg::CODE_W-1:0]    out_code,
    output logic [cqit_pkg::LEN_W-1:0]     out_length,
    output logic                           has_op,
    output logic                           end_of_record,
    output logic                           overflow
);

    localparam int IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int CNT_W = $clog2(MAX_HELD + 1);

    logic [cqit_pkg::CODE_W-1:0]  it_code_reg;
    logic [cqit_pkg::LEN_W-1:0]   it_len_reg;
    logic [cqit_pkg::POS_W-1:0]   it_s_reg;
    logic [cqit_pkg::POS_W-1:0]   it_e_reg;
    logic                         it_last_reg;

    logic [cqit_pkg::CUR_W-1:0]   cursor_reg;
    logic                         inside_reg;
    logic                         done_reg;
    logic                         emitted_reg;
    logic [CNT_W-1:0]             held_count_reg;
    logic                         ovf_reg;
    logic [CNT_W-1:0]             flush_cnt_reg;
    logic [CNT_W-1:0]             flush_idx_reg;
    logic [cqit_pkg::CODE_W-1:0]  res_code_reg;
    logic [cqit_pkg::LEN_W-1:0]   res_len_reg;

    logic [cqit_pkg::ENTRY_W-1:0] held_mem [MAX_HELD];
    logic [cqit_pkg::ENTRY_W-1:0] rd_data_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [cqit_pkg::CODE_W-1:0]  out_code_reg;
    logic [cqit_pkg::LEN_W-1:0]   out_length_reg;
    logic                         has_op_reg;
    logic                         eor_reg;
    logic                         ovf_out_reg;

    logic [cqit_pkg::POS_W-1:0]   e_eff;
    logic [cqit_pkg::CUR_W-1:0]   e_ext;
    logic [cqit_pkg::CUR_W-1:0]   s_ext;
    logic                         cons;
    logic [cqit_pkg::CUR_W-1:0]   after;
    logic                         end_cross;
    logic                         enter;
    logic [cqit_pkg::CUR_W-1:0]   nl_cross;
    logic                         keep_it;
    logic [cqit_pkg::LEN_W-1:0]   res_len;
    logic                         emit;
    logic                         hold;
    logic                         drop_full;
    logic [CNT_W-1:0]             flush_idx_inc;
    logic [CNT_W-1:0]             rd_addr_full;
    logic [IDX_W-1:0]             rd_addr;

    always_comb
    begin
        e_eff     = (it_e_reg < it_s_reg) ? it_s_reg : it_e_reg;
        e_ext     = {1'b0, e_eff};
        s_ext     = {1'b0, it_s_reg};
        cons      = cqit_pkg::CONSUME_MASK[it_code_reg];
        after     = cons ? cursor_reg + {{(cqit_pkg::CUR_W - cqit_pkg::LEN_W){1'b0}}, it_len_reg}
                         : cursor_reg;
        end_cross = after > e_ext;
        enter     = (after > s_ext) && !inside_reg;
        if (inside_reg)
        begin
            nl_cross = (e_ext >= cursor_reg) ? e_ext - cursor_reg : '0;
        end
        else
        begin
            nl_cross = e_ext - s_ext;
        end

        keep_it   = 1'b0;
        res_len   = it_len_reg;
        emit      = 1'b0;
        hold      = 1'b0;
        drop_full = 1'b0;
        if (!done_reg)
        begin
            if (end_cross)
            begin
                res_len = cqit_pkg::sat_len(nl_cross);
                emit    = (nl_cross != '0) && (cons || !emitted_reg);
            end
            else if (enter)
            begin
                keep_it = 1'b1;
                res_len = cqit_pkg::sat_len(after - s_ext);
            end
            else if (inside_reg)
            begin
                keep_it = 1'b1;
            end
        end
        if (keep_it)
        begin
            if (cons || !emitted_reg)
            begin
                emit = 1'b1;
            end
            else if (held_count_reg < CNT_W'(MAX_HELD))
            begin
                hold = 1'b1;
            end
            else
            begin
                drop_full = 1'b1;
            end
        end
    end

    assign flush_idx_inc = flush_idx_reg + CNT_W'(1);

    always_comb
    begin
        if (cmd.emit_held)
        begin
            rd_addr_full = flush_idx_inc;
        end
        else if (cmd.eval)
        begin
            rd_addr_full = '0;
        end
        else
        begin
            rd_addr_full = flush_idx_reg;
        end
    end

    assign rd_addr = rd_addr_full[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.eval && hold)
        begin
            held_mem[held_count_reg[IDX_W-1:0]] <= {res_len, it_code_reg};
        end
        rd_data_reg <= held_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_code_reg <= op_code;
            it_len_reg  <= op_length;
            it_s_reg    <= trim_start;
            it_e_reg    <= trim_end;
        end
        if (cmd.eval)
        begin
            res_code_reg <= it_code_reg;
            res_len_reg  <= res_len;
        end
        if (cmd.emit_held)
        begin
            out_code_reg   <= rd_data_reg[cqit_pkg::CODE_W-1:0];
            out_length_reg <= rd_data_reg[cqit_pkg::ENTRY_W-1:cqit_pkg::CODE_W];
            has_op_reg     <= 1'b1;
            eor_reg        <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else if (cmd.emit_op)
        begin
            out_code_reg   <= res_code_reg;
            out_length_reg <= res_len_reg;
            has_op_reg     <= 1'b1;
            eor_reg        <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            out_code_reg   <= '0;
            out_length_reg <= '0;
            has_op_reg     <= 1'b0;
            eor_reg        <= 1'b1;
            ovf_out_reg    <= ovf_reg;
        end
    end

    always_comb
    begin
        if (cmd.emit_held || cmd.emit_op || cmd.emit_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_last_reg    <= 1'b0;
            cursor_reg     <= '0;
            inside_reg     <= 1'b0;
            done_reg       <= 1'b0;
            emitted_reg    <= 1'b0;
            held_count_reg <= '0;
            ovf_reg        <= 1'b0;
            flush_cnt_reg  <= '0;
            flush_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                it_last_reg <= last_op;
            end
            if (cmd.eval && !done_reg)
            begin
                cursor_reg <= after;
                if (end_cross)
                begin
                    done_reg <= 1'b1;
                end
                else if (enter)
                begin
                    inside_reg <= 1'b1;
                end
                if (emit)
                begin
                    emitted_reg   <= 1'b1;
                    flush_cnt_reg <= held_count_reg;
                    flush_idx_reg <= '0;
                end
                if (end_cross || emit)
                begin
                    held_count_reg <= '0;
                end
                else if (hold)
                begin
                    held_count_reg <= held_count_reg + CNT_W'(1);
                end
                if (drop_full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.emit_held)
            begin
                flush_idx_reg <= flush_idx_inc;
            end
            if (cmd.emit_end)
            begin
                cursor_reg     <= '0;
                inside_reg     <= 1'b0;
                done_reg       <= 1'b0;
                emitted_reg    <= 1'b0;
                held_count_reg <= '0;
                ovf_reg        <= 1'b0;
            end
        end
    end

    assign status.emit_now   = emit;
    assign status.flush_now  = emit && (held_count_reg != '0);
    assign status.flush_last = (flush_idx_inc == flush_cnt_reg);
    assign status.rec_last   = it_last_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign out_code      = out_code_reg;
    assign out_length    = out_length_reg;
    assign has_op        = has_op_reg;
    assign end_of_record = eor_reg;
    assign overflow      = ovf_out_reg;

endmodule

/* design/cqit_ctrl.sv */
`timescale 1ns / 1ps

module cqit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cqit_pkg::status_t status,
    output cqit_pkg::cmd_t    cmd
);

    cqit_pkg::state_t state_reg;
    cqit_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqit_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cqit_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cqit_pkg::S_EVAL;
                end
            end
            cqit_pkg::S_EVAL:
            begin
                if (status.flush_now)
                begin
                    state_next = cqit_pkg::S_FLUSH;
                end
                else if (status.emit_now)
                begin
                    state_next = cqit_pkg::S_OP;
                end
                else if (status.rec_last)
                begin
                    state_next = cqit_pkg::S_END;
                end
                else
                begin
                    state_next = cqit_pkg::S_IDLE;
                end
            end
            cqit_pkg::S_FLUSH:
            begin
                if (status.out_free && status.flush_last)
                begin
                    state_next = cqit_pkg::S_OP;
                end
            end
            cqit_pkg::S_OP:
            begin
                if (status.out_free)
                begin
                    state_next = status.rec_last ? cqit_pkg::S_END : cqit_pkg::S_IDLE;
                end
            end
            cqit_pkg::S_END:
            begin
                if (status.out_free)
                begin
                    state_next = cqit_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cqit_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            cqit_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            cqit_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            cqit_pkg::S_FLUSH:
            begin
                cmd.emit_held = status.out_free;
            end
            cqit_pkg::S_OP:
            begin
                cmd.emit_op = status.out_free;
            end
            cqit_pkg::S_END:
            begin
                cmd.emit_end = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/cigar_query_interval_trim.sv */
// Trims a record's CIGAR ops, streamed one per transaction, to the query interval
// [trim_start, trim_end) and streams out the kept ops, closing each record with an
// end marker on the transaction flagged last_op. Each op is accepted, then evaluated;
// any held non-query ops are then released before it, then the kept op is sent and,
// after the last op, the end marker; output stalls hold each of these steps.
// The rate is set by the controller stepping through these phases one at a time
// and by the single read port of the held-op buffer (MAX_HELD entries).
`timescale 1ns / 1ps

module cigar_query_interval_trim #(
    parameter int MAX_HELD = cqit_pkg::MAX_HELD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cqit_pkg::CODE_W-1:0] op_code,
    input  logic [cqit_pkg::LEN_W-1:0]  op_length,
    input  logic [cqit_pkg::POS_W-1:0]  trim_start,
    input  logic [cqit_pkg::POS_W-1:0]  trim_end,
    input  logic                        last_op,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cqit_pkg::CODE_W-1:0] out_code,
    output logic [cqit_pkg::LEN_W-1:0]  out_length,
    output logic                        has_op,
    output logic                        end_of_record,
    output logic                        overflow
);

    cqit_pkg::cmd_t    cmd;
    cqit_pkg::status_t status;

    cqit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cqit_datapath #(
        .MAX_HELD (MAX_HELD)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op_code       (op_code),
        .op_length     (op_length),
        .trim_start    (trim_start),
        .trim_end      (trim_end),
        .last_op       (last_op),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_code      (out_code),
        .out_length    (out_length),
        .has_op        (has_op),
        .end_of_record (end_of_record),
        .overflow      (overflow)
    );

endmodule

/* design/cqit_checker.sv */
`timescale 1ns / 1ps
`include "cigar_query_interval_trim_macros.svh"

module cqit_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [cqit_pkg::CODE_W-1:0] out_code,
    input logic [cqit_pkg::LEN_W-1:0]  out_length,
    input logic                        has_op,
    input logic                        end_of_record,
    input logic                        overflow
);

    `CQIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code) && $stable(out_length) && $stable(end_of_record), "stalled output transaction changed")
    `CQIT_ASSERT_NOW(a_kind, out_valid, has_op != end_of_record, "transaction is neither op nor end marker")
    `CQIT_ASSERT_NOW(a_end_empty, out_valid && end_of_record, out_code == '0 && out_length == '0, "end marker carries an op")
    `CQIT_ASSERT_NOW(a_ovf_end, out_valid && !end_of_record, !overflow, "overflow flagged on an op")

endmodule

bind cigar_query_interval_trim cqit_checker u_cqit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code      (out_code),
    .out_length    (out_length),
    .has_op        (has_op),
    .end_of_record (end_of_record),
    .overflow      (overflow)
);
